// ----- src/bmhq_pkg.sv -----
// Package for the heap queue: sizes, operation and status codes, control types.
`timescale 1ns / 1ps

package bmhq_pkg;

  // Heap geometry
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  // child index of the deepest node needs two more bits than an address
  localparam int CIDX_W   = ADDR_W + 2;

  // Beat field widths
  localparam int KEY_W    = 32;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 8;
  localparam int CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_DELETE = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_UPDATE = MODE_W'(2);

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY  = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_BADPOS = STATUS_W'(3);

  // One datapath step per cycle
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,      // clear removed value (error or no-op beats)
    DP_INS_START,  // hole at the tail, key from the beat, count up
    DP_UPD_START,  // hole at the given position, key from the beat
    DP_DEL_READ,   // read root and last entry
    DP_DEL_START,  // take the root, last entry becomes the key, count down
    DP_UP_READ,    // read the parent of the hole
    DP_UP_MOVE,    // parent moves down into the hole
    DP_DN_READ,    // read both children of the hole
    DP_DN_MOVE,    // larger child moves up into the hole
    DP_PLACE,      // key lands in the hole
    DP_RESULT      // load the result register
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic at_root;
    logic up_gt;
    logic dn_move;
  } dp_sts_t;

endpackage

// ----- src/bmhq_if.sv -----
// Request and response channel interfaces of the heap queue.
`timescale 1ns / 1ps

interface bmhq_req_if
  import bmhq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [KEY_W-1:0]  value;
  logic [POS_W-1:0]         position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface bmhq_rsp_if
  import bmhq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [KEY_W-1:0]  removed_value;
  logic [ENTRY_W-1:0]       entry_count;

  modport source (output valid, status, removed_value, entry_count, input ready);
  modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

// ----- src/binary_max_heap_queue.sv -----
// Sequence: accept, sift the hole up or down with one store read and one compare per
//   level, place the key, then load the result register.
// Throughput: one operation at a time; the next request is taken only when the
//   controller is back in idle.
// Reset: entry count and control clear at once; the key store is not cleared.
`timescale 1ns / 1ps

module binary_max_heap_queue
  import bmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.mode),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store and sift datapath
  bmhq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (req_i.value),
    .position_i      (req_i.position),
    .sts_o           (sts),
    .status_o        (rsp_o.status),
    .removed_value_o (rsp_o.removed_value),
    .entry_count_o   (rsp_o.entry_count)
  );

endmodule

// ----- src/bmhq_datapath.sv -----
// Heap datapath: key store, sift hole and key, count, comparators, result register.
`timescale 1ns / 1ps

module bmhq_datapath
  import bmhq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic signed [KEY_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  output dp_sts_t                 sts_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic signed [KEY_W-1:0] removed_value_o,
  output logic [ENTRY_W-1:0]      entry_count_o
);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic signed [KEY_W-1:0] rd_a_q, rd_b_q;
  logic signed [KEY_W-1:0] key_q, removed_q;
  logic [ADDR_W-1:0]       at_q;
  logic [COUNT_W-1:0]      count_q;
  logic [STATUS_W-1:0]     status_q;
  logic signed [KEY_W-1:0] removed_out_q;
  logic [COUNT_W-1:0]      count_out_q;

  logic [ADDR_W-1:0]       raddr_a, raddr_b;
  logic [ADDR_W-1:0]       parent;
  logic [CIDX_W-1:0]       left_idx, right_idx, move_idx;
  logic                    left_ok, right_ok, left_gt, right_gt;
  logic signed [KEY_W-1:0] best_val, move_val, wdata;
  logic                    we;

  // Tree neighbors of the hole
  assign parent    = (at_q - 1'b1) >> 1;
  assign left_idx  = {1'b0, at_q, 1'b1};
  assign right_idx = left_idx + 1'b1;

  // Sift-down choice among the key and the children still in the heap
  assign left_ok  = left_idx < CIDX_W'(count_q);
  assign right_ok = right_idx < CIDX_W'(count_q);
  assign left_gt  = left_ok && (rd_a_q > key_q);
  assign best_val = left_gt ? rd_a_q : key_q;
  assign right_gt = right_ok && (rd_b_q > best_val);
  assign move_val = right_gt ? rd_b_q : rd_a_q;
  assign move_idx = right_gt ? right_idx : left_idx;

  // Status toward the controller
  assign sts_o.full    = count_q == COUNT_W'(CAPACITY);
  assign sts_o.empty   = count_q == '0;
  assign sts_o.pos_bad = CMP_W'(position_i) >= CMP_W'(count_q);
  assign sts_o.at_root = at_q == '0;
  assign sts_o.up_gt   = key_q > rd_a_q;
  assign sts_o.dn_move = left_gt || right_gt;

  // Read addresses, and a write port that is always at the hole
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    wdata   = key_q;
    case (cmd_i.op)
      DP_DEL_READ: begin
        raddr_b = ADDR_W'(count_q - 1'b1);
      end
      DP_UP_READ: begin
        raddr_a = parent;
      end
      DP_DN_READ: begin
        raddr_a = left_idx[ADDR_W-1:0];
        raddr_b = right_idx[ADDR_W-1:0];
      end
      DP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rd_a_q;
      end
      DP_DN_MOVE: begin
        we    = 1'b1;
        wdata = move_val;
      end
      DP_PLACE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Key store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[at_q] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == DP_INS_START) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.op == DP_DEL_START) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Hole position, moving key and removed value
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_CLEAR, DP_DEL_READ: begin
        removed_q <= '0;
      end
      DP_INS_START: begin
        removed_q <= '0;
        key_q     <= value_i;
        at_q      <= ADDR_W'(count_q);
      end
      DP_UPD_START: begin
        removed_q <= '0;
        key_q     <= value_i;
        at_q      <= ADDR_W'(position_i);
      end
      DP_DEL_START: begin
        removed_q <= rd_a_q;
        key_q     <= rd_b_q;
        at_q      <= '0;
      end
      DP_UP_MOVE: begin
        at_q <= parent;
      end
      DP_DN_MOVE: begin
        at_q <= move_idx[ADDR_W-1:0];
      end
      default: begin
        at_q <= at_q;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RESULT) begin
      status_q      <= cmd_i.status;
      removed_out_q <= removed_q;
      count_out_q   <= count_q;
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_out_q;
  assign entry_count_o   = ENTRY_W'(count_out_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_INS_START |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not advance the count");

  a_move_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_DN_MOVE |-> move_idx < CIDX_W'(count_q))
    else $error("sift-down moved a child from outside the heap");

endmodule

// ----- src/bmhq_ctrl.sv -----
// Heap controller: operation sequencing and response handshake.
`timescale 1ns / 1ps

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [MODE_W-1:0] req_mode_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  dp_sts_t           sts_i,
  output dp_cmd_t           cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DEL_LD = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                upd_q, upd_d;
  logic                rsp_valid_q, rsp_valid_d;

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = rsp_valid_q;

  // Next state and datapath step
  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    upd_d         = upd_q;
    cmd_o.op      = DP_NONE;
    cmd_o.status  = status_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          status_d = ST_OK;
          upd_d    = 1'b0;
          state_d  = S_FIN;
          cmd_o.op = DP_CLEAR;
          case (req_mode_i)
            MODE_INSERT: begin
              if (sts_i.full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.op = DP_INS_START;
                state_d  = S_UP_RD;
              end
            end
            MODE_DELETE: begin
              if (sts_i.empty) begin
                status_d = ST_EMPTY;
              end else begin
                cmd_o.op = DP_DEL_READ;
                state_d  = S_DEL_LD;
              end
            end
            MODE_UPDATE: begin
              if (sts_i.pos_bad) begin
                status_d = ST_BADPOS;
              end else begin
                cmd_o.op = DP_UPD_START;
                upd_d    = 1'b1;
                state_d  = S_UP_RD;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (!sts_i.at_root) begin
          cmd_o.op = DP_UP_READ;
          state_d  = S_UP_CMP;
        end else if (upd_q) begin
          // root has no parent: an update there always sifts down
          state_d = S_DN_RD;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_gt) begin
          cmd_o.op = DP_UP_MOVE;
          upd_d    = 1'b0;
          state_d  = S_UP_RD;
        end else if (upd_q) begin
          state_d = S_DN_RD;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_DEL_LD: begin
        cmd_o.op = DP_DEL_START;
        state_d  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.op = DP_DN_READ;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_move) begin
          cmd_o.op = DP_DN_MOVE;
          state_d  = S_DN_RD;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (cmd_o.op == DP_RESULT) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      upd_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      upd_q       <= upd_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == DP_RESULT |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result register overwritten while a beat is pending");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("response beat dropped before it was taken");

  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= S_FIN)
    else $error("controller in an unused state");

endmodule

// ----- tb/sv/tb_binary_max_heap_queue.sv -----
// Testbench for the binary max-heap queue: random and directed operations checked against a heap model.
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  // Mode 3 has no operation behind it; the block reports ok and leaves the heap alone
  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(3);

  localparam int RANDOM_OPS = 800;
  localparam int HOLD_AT    = 150;   // results before the long receiver hold-off
  localparam int HOLD_LEN   = 400;   // cycles of the hold-off
  localparam int QUIET_LO   = 300;   // window without random idling on either side
  localparam int QUIET_HI   = 450;
  localparam int STALL_MAX  = 3000;  // cycles without any beat before giving up
  localparam int TAIL_WAIT  = 40;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] value;
    logic [POS_W-1:0]        position;
    bit                      wait_drain;  // hold back until every earlier reply is in
  } heap_op_t;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed;
    logic [ENTRY_W-1:0]      count;
  } heap_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bmhq_req_if req_bus ();
  bmhq_rsp_if rsp_bus ();

  binary_max_heap_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Heap image kept by the testbench
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned             heap_size = 0;

  heap_op_t    op_backlog[$];
  heap_reply_t predicted_replies[$];

  int unsigned ops_sent     = 0;
  int unsigned replies_seen = 0;
  int unsigned total_ops    = 0;
  int unsigned fail_count   = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_cycles = 0;

  // Stimulus-side bookkeeping of the key count, used to aim update positions
  int unsigned gen_count  = 0;
  bit          drain_next = 1'b0;

  function automatic void sift_up(int unsigned at);
    int unsigned             up;
    logic signed [KEY_W-1:0] t;
    bit                      done;
    done = 1'b0;
    while (at != 0 && !done) begin
      up = (at - 1) / 2;
      if (heap_keys[at] > heap_keys[up]) begin
        t = heap_keys[at];
        heap_keys[at] = heap_keys[up];
        heap_keys[up] = t;
        at = up;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  function automatic void sift_down(int unsigned at);
    int unsigned             best;
    int unsigned             lc;
    logic signed [KEY_W-1:0] t;
    bit                      done;
    done = 1'b0;
    while (!done) begin
      best = at;
      lc   = 2 * at + 1;
      if (lc < heap_size && heap_keys[lc] > heap_keys[best]) best = lc;
      if (lc + 1 < heap_size && heap_keys[lc + 1] > heap_keys[best]) best = lc + 1;
      if (best == at) begin
        done = 1'b1;
      end else begin
        t = heap_keys[at];
        heap_keys[at] = heap_keys[best];
        heap_keys[best] = t;
        at = best;
      end
    end
  endfunction

  // Apply one operation to the heap image and return the reply it should produce
  function automatic heap_reply_t heap_apply(heap_op_t op);
    heap_reply_t res;
    int unsigned p;
    p           = op.position;
    res.status  = ST_OK;
    res.removed = '0;
    case (op.mode)
      MODE_INSERT: begin
        if (heap_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_keys[heap_size] = op.value;
          sift_up(heap_size);
          heap_size++;
        end
      end
      MODE_DELETE: begin
        if (heap_size == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed  = heap_keys[0];
          heap_keys[0] = heap_keys[heap_size - 1];
          heap_size--;
          sift_down(0);
        end
      end
      MODE_UPDATE: begin
        if (p >= heap_size) begin
          res.status = ST_BADPOS;
        end else begin
          heap_keys[p] = op.value;
          // root has no parent: always sift down
          if (p != 0 && op.value > heap_keys[(p - 1) / 2]) sift_up(p);
          else sift_down(p);
        end
      end
      default: ;
    endcase
    res.count = ENTRY_W'(heap_size);
    return res;
  endfunction

  task automatic add_op(input logic [MODE_W-1:0] mode, input logic signed [KEY_W-1:0] value,
                        input logic [POS_W-1:0] position);
    heap_op_t op;
    op.mode       = mode;
    op.value      = value;
    op.position   = position;
    op.wait_drain = drain_next;
    drain_next    = 1'b0;
    op_backlog.push_back(op);
    total_ops++;
    if (mode == MODE_INSERT && gen_count < CAPACITY) gen_count++;
    if (mode == MODE_DELETE && gen_count > 0) gen_count--;
  endtask

  // Mix of full-range keys, a narrow band for ties, the extremes and small non-negative keys
  function automatic logic signed [KEY_W-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return $signed($urandom_range(0, 15)) - 8;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom_range(0, 1000);
  endfunction

  // One random operation; weights in percent, the remainder goes to the unused mode
  task automatic rand_op(input int ins_w, input int del_w, input int upd_w,
                         output logic [MODE_W-1:0] mode);
    int unsigned      r;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, 127));
    if (r < ins_w) mode = MODE_INSERT;
    else if (r < ins_w + del_w) mode = MODE_DELETE;
    else if (r < ins_w + del_w + upd_w) mode = MODE_UPDATE;
    else mode = MODE_NONE;
    if (mode == MODE_UPDATE) begin
      // mostly a live entry, sometimes a position past the count
      if (gen_count > 0 && $urandom_range(0, 99) < 90) begin
        pos = POS_W'($urandom_range(0, gen_count - 1));
      end else if (gen_count < CAPACITY) begin
        pos = POS_W'($urandom_range(gen_count, 127));
      end
    end
    add_op(mode, rand_key(), pos);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    heap_op_t nxt;
    bit       quiet;
    if (!rst_ni) begin
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= MODE_INSERT;
      req_bus.value    <= '0;
      req_bus.position <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        nxt.mode       = req_bus.mode;
        nxt.value      = req_bus.value;
        nxt.position   = req_bus.position;
        nxt.wait_drain = 1'b0;
        predicted_replies.push_back(heap_apply(nxt));
        ops_sent++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        quiet = ops_sent >= QUIET_LO && ops_sent < QUIET_HI;
        if (op_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 27) &&
            (!op_backlog[0].wait_drain || replies_seen == ops_sent)) begin
          nxt = op_backlog.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.mode     <= nxt.mode;
          req_bus.value    <= nxt.value;
          req_bus.position <= nxt.position;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    heap_reply_t want;
    bit          quiet;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      replies_seen  <= 0;
      hold_left     = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        replies_seen <= replies_seen + 1;
        if (predicted_replies.size() == 0) begin
          $error("reply beat with nothing outstanding: status %0d count %0d",
                 rsp_bus.status, rsp_bus.entry_count);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.removed_value !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed,
                   rsp_bus.removed_value);
            fail_count++;
          end
          if (rsp_bus.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, rsp_bus.entry_count);
            fail_count++;
          end
        end
        if (replies_seen + 1 == HOLD_AT) hold_left = HOLD_LEN;
      end
      quiet = replies_seen >= QUIET_LO && replies_seen < QUIET_HI;
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= quiet || $urandom_range(0, 99) >= 27;
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_MAX) begin
        $error("no beat for %0d cycles", stall_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    int unsigned       hits;
    int unsigned       phase;
    int unsigned       kind;
    int unsigned       len;

    // Directed: empty-heap errors, extremes, updates at root and leaf, drain past empty
    add_op(MODE_DELETE, 0, 0);
    add_op(MODE_UPDATE, 7, 0);
    add_op(MODE_UPDATE, 7, 127);
    add_op(MODE_NONE, 32'sh5A5A_A5A5, 64);
    add_op(MODE_INSERT, 32'sh7FFF_FFFF, 0);
    add_op(MODE_INSERT, 32'sh8000_0000, 127);
    add_op(MODE_INSERT, 0, 0);
    add_op(MODE_INSERT, -1, 0);
    add_op(MODE_INSERT, 5, 0);
    add_op(MODE_UPDATE, 9, 5);
    add_op(MODE_UPDATE, 32'sh8000_0000, 0);
    add_op(MODE_UPDATE, 32'sh7FFF_FFFF, 4);
    add_op(MODE_UPDATE, 0, 3);
    add_op(MODE_NONE, -1, 127);
    repeat (6) add_op(MODE_DELETE, 0, 0);
    add_op(MODE_INSERT, 3, 0);
    add_op(MODE_UPDATE, 32'sh8000_0000, 0);
    add_op(MODE_DELETE, 0, 0);

    // Random phases: fill to full, drain to empty, or a mixed run
    drain_next = 1'b1;
    phase      = 0;
    while (total_ops < RANDOM_OPS + 23) begin
      kind = (phase == 0) ? 0 : $urandom_range(0, 3);
      if (phase % 3 == 2) drain_next = 1'b1;
      hits = 0;
      if (kind == 0) begin
        while (hits < 3) begin
          if (gen_count == CAPACITY) hits++;
          rand_op(85, 10, 5, mode);
        end
      end else if (kind == 1) begin
        while (hits < 2) begin
          if (gen_count == 0) hits++;
          rand_op(10, 85, 5, mode);
        end
      end else begin
        len = $urandom_range(20, 60);
        repeat (len) rand_op(35, 30, 30, mode);
      end
      phase++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (replies_seen < total_ops) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (predicted_replies.size() != 0) begin
      $error("%0d replies never arrived", predicted_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
